// ===== design/hffl_pkg.sv =====
`default_nettype none

package hffl_pkg;

  localparam int NumSlots = 64;
  localparam int SizeBits = 32;
  localparam int SlotW    = $clog2(NumSlots);
  localparam int LinkW    = SlotW + 1;

  localparam logic [LinkW-1:0] NilSlot = LinkW'(NumSlots);

  typedef logic [LinkW-1:0]    link_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [SizeBits-1:0] size_t;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_LINK   = 2'd1,
    FUNC_UNLINK = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FIX
  } state_e;

  function automatic logic is_slot(input link_t lk);
    return lk < NilSlot;
  endfunction

endpackage

`default_nettype wire

// ===== design/head_fit_free_list_top.sv =====
`default_nettype none

// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------------------
// command   | in        | start, busy              | func_i, block_index_i, block_size_i
// result    | out       | valid_o (one-cycle pulse)| found_o, granted_block_o
//
// One command is worked at a time. An accepted command passes through the READ and
// EVAL states, and a link also through FIX, before the result strobe; the next command
// can be accepted at the edge that ends the strobe. READ waits on the registered reads
// of the link and size memories, EVAL decides and writes, and FIX writes back up to two
// neighbor entries of a link. busy is high from the accepting edge until the result
// strobe. Reset empties the list; the link and size memories are not cleared. The
// receiver cannot stall the result.
module head_fit_free_list_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 func_i,
  input  wire logic [hffl_pkg::SlotW-1:0] block_index_i,
  input  wire logic [hffl_pkg::SizeBits-1:0] block_size_i,
  output logic                            valid_o,
  output logic                            found_o,
  output logic [hffl_pkg::SlotW-1:0]      granted_block_o
);

  // Link and size memories.
  hffl_pkg::link_t next_mem [hffl_pkg::NumSlots];
  hffl_pkg::link_t prev_mem [hffl_pkg::NumSlots];
  hffl_pkg::size_t size_mem [hffl_pkg::NumSlots];

  hffl_pkg::state_e state_q, state_d;
  hffl_pkg::func_e  func_q;
  hffl_pkg::slot_t  blk_q;
  hffl_pkg::size_t  size_q;
  hffl_pkg::link_t  head_q, head_d;
  hffl_pkg::link_t  fix_next_q, fix_next_d;
  hffl_pkg::link_t  fix_prev_q, fix_prev_d;
  logic             valid_q, valid_d;
  logic             found_q, found_d;
  hffl_pkg::slot_t  granted_q, granted_d;

  // Memory ports.
  hffl_pkg::slot_t next_raddr, prev_raddr, size_raddr;
  hffl_pkg::link_t next_rdata, prev_rdata;
  hffl_pkg::size_t size_rdata;
  logic            next_we, prev_we, size_we;
  hffl_pkg::slot_t next_waddr, prev_waddr;
  hffl_pkg::link_t next_wdata, prev_wdata;

  logic accept;
  logic head_bigger;

  assign accept = start && !busy;
  assign busy   = (state_q != hffl_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rdata <= next_mem[next_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rdata <= prev_mem[prev_raddr];
  end

  // The freed size is written while the head size is being read; when the
  // block is the head itself the read returns the old size, and the compare
  // below excludes it by its index.
  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[blk_q] <= size_q;
    end
    size_rdata <= size_mem[size_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= hffl_pkg::func_e'(func_i);
      blk_q  <= block_index_i;
      size_q <= block_size_i;
    end
    fix_next_q <= fix_next_d;
    fix_prev_q <= fix_prev_d;
    found_q    <= found_d;
    granted_q  <= granted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hffl_pkg::ST_IDLE;
      head_q  <= hffl_pkg::NilSlot;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      valid_q <= valid_d;
    end
  end

  assign size_raddr = head_q[hffl_pkg::SlotW-1:0];
  assign next_raddr = (func_q == hffl_pkg::FUNC_UNLINK) ? blk_q
                                                        : head_q[hffl_pkg::SlotW-1:0];
  assign prev_raddr = blk_q;

  assign head_bigger = hffl_pkg::is_slot(head_q)
                       && (head_q != {1'b0, blk_q})
                       && (size_rdata > size_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fix_next_d = fix_next_q;
    fix_prev_d = fix_prev_q;
    valid_d    = 1'b0;
    found_d    = found_q;
    granted_d  = granted_q;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    size_we    = 1'b0;
    next_waddr = blk_q;
    prev_waddr = blk_q;
    next_wdata = hffl_pkg::NilSlot;
    prev_wdata = hffl_pkg::NilSlot;

    unique case (state_q)
      hffl_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = hffl_pkg::ST_READ;
        end
      end

      hffl_pkg::ST_READ: begin
        size_we = (func_q == hffl_pkg::FUNC_LINK);
        state_d = hffl_pkg::ST_EVAL;
      end

      hffl_pkg::ST_EVAL: begin
        found_d   = 1'b0;
        granted_d = '0;
        state_d   = hffl_pkg::ST_IDLE;
        valid_d   = 1'b1;
        unique case (func_q)
          hffl_pkg::FUNC_GET: begin
            if (hffl_pkg::is_slot(head_q) && (size_rdata >= size_q)) begin
              found_d   = 1'b1;
              granted_d = head_q[hffl_pkg::SlotW-1:0];
              head_d    = hffl_pkg::is_slot(next_rdata) ? next_rdata : hffl_pkg::NilSlot;
              if (hffl_pkg::is_slot(next_rdata)) begin
                prev_we    = 1'b1;
                prev_waddr = next_rdata[hffl_pkg::SlotW-1:0];
                prev_wdata = hffl_pkg::NilSlot;
              end
            end
          end

          hffl_pkg::FUNC_LINK: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            valid_d = 1'b0;
            state_d = hffl_pkg::ST_FIX;
            if (head_bigger) begin
              // Insert second, after the larger head.
              next_wdata = next_rdata;
              prev_wdata = head_q;
              fix_next_d = head_q;
              fix_prev_d = next_rdata;
            end else begin
              next_wdata = head_q;
              prev_wdata = hffl_pkg::NilSlot;
              head_d     = {1'b0, blk_q};
              fix_next_d = hffl_pkg::NilSlot;
              fix_prev_d = head_q;
            end
          end

          hffl_pkg::FUNC_UNLINK: begin
            // prev_rdata and next_rdata hold the block's own neighbors.
            if (hffl_pkg::is_slot(prev_rdata)) begin
              next_we    = 1'b1;
              next_waddr = prev_rdata[hffl_pkg::SlotW-1:0];
              next_wdata = next_rdata;
            end else begin
              head_d = hffl_pkg::is_slot(next_rdata) ? next_rdata : hffl_pkg::NilSlot;
            end
            if (hffl_pkg::is_slot(next_rdata)) begin
              prev_we    = 1'b1;
              prev_waddr = next_rdata[hffl_pkg::SlotW-1:0];
              prev_wdata = hffl_pkg::is_slot(prev_rdata) ? prev_rdata : hffl_pkg::NilSlot;
            end
          end

          default: begin
          end
        endcase
      end

      hffl_pkg::ST_FIX: begin
        // Second write of a link: the neighbors now point at the new block.
        if (hffl_pkg::is_slot(fix_next_q)) begin
          next_we    = 1'b1;
          next_waddr = fix_next_q[hffl_pkg::SlotW-1:0];
          next_wdata = {1'b0, blk_q};
        end
        if (hffl_pkg::is_slot(fix_prev_q)) begin
          prev_we    = 1'b1;
          prev_waddr = fix_prev_q[hffl_pkg::SlotW-1:0];
          prev_wdata = {1'b0, blk_q};
        end
        valid_d = 1'b1;
        state_d = hffl_pkg::ST_IDLE;
      end

      default: begin
        state_d = hffl_pkg::ST_IDLE;
      end
    endcase
  end

  assign valid_o         = valid_q;
  assign found_o         = found_q;
  assign granted_block_o = granted_q;

endmodule

`default_nettype wire

// ===== tb/tb_head_fit_free_list_top.sv =====
`default_nettype none

module tb_head_fit_free_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hffl_pkg::*;

  localparam int PLAN       = 0;
  localparam int TRACK      = 1;
  localparam int RandItems  = 830;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic  hold;
    func_e f;
    slot_t blk;
    size_t size;
  } cmd_t;

  typedef struct packed {
    logic  found;
    slot_t grant;
  } grant_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  [1:0] func_i = 2'd0;
  slot_t block_index_i = '0;
  size_t block_size_i = '0;
  logic  valid_o;
  logic  found_o;
  slot_t granted_block_o;

  head_fit_free_list_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .block_index_i  (block_index_i),
    .block_size_i   (block_size_i),
    .valid_o        (valid_o),
    .found_o        (found_o),
    .granted_block_o(granted_block_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Two copies of the list: one the stimulus plans against, one that follows
  // the transfers actually taken by the block.
  link_t head_m [2] = '{NilSlot, NilSlot};
  link_t next_m [2][NumSlots];
  link_t prev_m [2][NumSlots];
  size_t size_m [2][NumSlots];

  logic  in_list [NumSlots];
  logic  ever_linked [NumSlots];
  int    members = 0;

  cmd_t   cmd_queue[$];
  grant_t pending_grants[$];
  cmd_t   next_cmd;
  logic   took = 1'b0;
  int     idle_left = 0;
  int     mismatches = 0;
  int     cycle_count = 0;

  function automatic grant_t free_list_step(input int c, input func_e f, input slot_t blk,
                                            input size_t size);
    grant_t r;
    link_t  h;
    link_t  p;
    link_t  n;
    r = '0;
    case (f)
      FUNC_GET: begin
        h = head_m[c];
        if (h < NilSlot && size_m[c][h[SlotW-1:0]] >= size) begin
          r.found = 1'b1;
          r.grant = h[SlotW-1:0];
          n = next_m[c][r.grant];
          head_m[c] = (n < NilSlot) ? n : NilSlot;
          if (n < NilSlot) prev_m[c][n[SlotW-1:0]] = NilSlot;
        end
      end
      FUNC_LINK: begin
        size_m[c][blk] = size;
        h = head_m[c];
        // A larger head stays in front and the freed slot goes second.
        if (h < NilSlot && size_m[c][h[SlotW-1:0]] > size) begin
          next_m[c][blk] = next_m[c][h[SlotW-1:0]];
          prev_m[c][blk] = h;
          next_m[c][h[SlotW-1:0]] = {1'b0, blk};
        end else begin
          next_m[c][blk] = h;
          prev_m[c][blk] = NilSlot;
          head_m[c] = {1'b0, blk};
        end
        n = next_m[c][blk];
        if (n < NilSlot) prev_m[c][n[SlotW-1:0]] = {1'b0, blk};
      end
      FUNC_UNLINK: begin
        p = prev_m[c][blk];
        n = next_m[c][blk];
        if (p < NilSlot) next_m[c][p[SlotW-1:0]] = n;
        else head_m[c] = (n < NilSlot) ? n : NilSlot;
        if (n < NilSlot) prev_m[c][n[SlotW-1:0]] = (p < NilSlot) ? p : NilSlot;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input func_e f, input slot_t blk, input size_t size,
                           input logic hold);
    grant_t r;
    cmd_t   c;
    r = free_list_step(PLAN, f, blk, size);
    if (f == FUNC_LINK) begin
      if (!in_list[blk]) members++;
      in_list[blk] = 1'b1;
      ever_linked[blk] = 1'b1;
    end else if (f == FUNC_UNLINK) begin
      if (in_list[blk]) members--;
      in_list[blk] = 1'b0;
    end else if (f == FUNC_GET && r.found) begin
      if (in_list[r.grant]) members--;
      in_list[r.grant] = 1'b0;
    end
    c.hold = hold;
    c.f    = f;
    c.blk  = blk;
    c.size = size;
    cmd_queue.push_back(c);
  endtask

  // Returns a slot with the wanted membership (and, if asked, one linked before), or -1 when there is none.
  function automatic int pick_slot(input logic want_member, input logic need_ever);
    int s;
    int base;
    base = $urandom_range(0, NumSlots - 1);
    for (int i = 0; i < NumSlots; i++) begin
      s = (base + i) % NumSlots;
      if (in_list[s] == want_member && (!need_ever || ever_linked[s])) return s;
    end
    return -1;
  endfunction

  function automatic size_t pick_size();
    size_t hs;
    hs = (head_m[PLAN] < NilSlot) ? size_m[PLAN][head_m[PLAN][SlotW-1:0]] : size_t'($urandom);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return size_t'($urandom_range(0, 255));
      3: return hs;
      4: return (hs == '1) ? hs : hs + 1'b1;
      default: return size_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input grant_t want, input grant_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected found=%0b granted=%0d, got found=%0b granted=%0d",
               $realtime, what, want.found, want.grant, got.found, got.grant);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // The current command is still waiting for its transfer.
    end else if (idle_left != 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (cmd_queue.size() == 0 ||
                 (cmd_queue[0].hold && pending_grants.size() != 0)) begin
      start <= 1'b0;
    end else begin
      next_cmd = cmd_queue.pop_front();
      func_i <= next_cmd.f;
      block_index_i <= next_cmd.blk;
      block_size_i <= next_cmd.size;
      start <= 1'b1;
      if (cmd_queue.size() > 100 && $urandom_range(0, 9) == 0)
        idle_left <= $urandom_range(1, 17);
    end
  end

  always @(posedge clk_i) begin
    grant_t want;
    grant_t got;
    if (rst_ni) begin
      // The result is checked before a transfer on the same edge is predicted.
      if (valid_o) begin
        got.found = found_o;
        got.grant = granted_block_o;
        if (pending_grants.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_grants.pop_front();
          if (found_o !== want.found || granted_block_o !== want.grant)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        pending_grants.push_back(free_list_step(TRACK, func_e'(func_i), block_index_i,
                                                block_size_i));
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int   roll;
    int   s;
    logic hold;
    for (int i = 0; i < NumSlots; i++) begin
      in_list[i] = 1'b0;
      ever_linked[i] = 1'b0;
    end

    queue_cmd(FUNC_GET, 6'd0, '0, 1'b0);
    queue_cmd(FUNC_GET, 6'd63, '1, 1'b0);
    queue_cmd(FUNC_NOP, 6'd63, '1, 1'b0);
    queue_cmd(FUNC_LINK, 6'd0, 32'd100, 1'b0);
    queue_cmd(FUNC_LINK, 6'd63, '1, 1'b0);
    queue_cmd(FUNC_LINK, 6'd5, 32'd50, 1'b0);
    queue_cmd(FUNC_LINK, 6'd10, '0, 1'b0);
    queue_cmd(FUNC_GET, 6'd7, '1, 1'b0);
    queue_cmd(FUNC_GET, 6'd0, 32'd1, 1'b0);
    queue_cmd(FUNC_GET, 6'd0, '0, 1'b0);
    queue_cmd(FUNC_LINK, 6'd63, 32'd7, 1'b0);
    queue_cmd(FUNC_UNLINK, 6'd63, '1, 1'b1);
    queue_cmd(FUNC_UNLINK, 6'd5, '0, 1'b0);
    queue_cmd(FUNC_UNLINK, 6'd0, '0, 1'b0);
    queue_cmd(FUNC_LINK, 6'd42, '0, 1'b0);
    queue_cmd(FUNC_LINK, 6'd21, '0, 1'b0);
    queue_cmd(FUNC_UNLINK, 6'd42, '0, 1'b0);
    queue_cmd(FUNC_GET, 6'd0, '0, 1'b0);
    queue_cmd(FUNC_NOP, 6'd0, '0, 1'b0);

    for (int k = 0; k < RandItems; k++) begin
      hold = ($urandom_range(0, 199) == 0);
      roll = $urandom_range(0, 99);
      if (members < 3 && roll >= 75) roll = 50;
      if (members > 40 && roll >= 40 && roll < 75) roll = 80;
      if (roll < 5) begin
        queue_cmd(FUNC_NOP, slot_t'($urandom), size_t'($urandom), hold);
      end else if (roll < 7) begin
        // Broken sequences: relink a member or unlink a slot that has left.
        if ($urandom_range(0, 1)) begin
          s = pick_slot(1'b1, 1'b0);
          if (s >= 0) queue_cmd(FUNC_LINK, slot_t'(s), pick_size(), hold);
          else queue_cmd(FUNC_NOP, slot_t'($urandom), size_t'($urandom), hold);
        end else begin
          s = pick_slot(1'b0, 1'b1);
          if (s >= 0) queue_cmd(FUNC_UNLINK, slot_t'(s), size_t'($urandom), hold);
          else queue_cmd(FUNC_NOP, slot_t'($urandom), size_t'($urandom), hold);
        end
      end else if (roll < 40) begin
        queue_cmd(FUNC_GET, slot_t'($urandom), pick_size(), hold);
      end else if (roll < 75) begin
        s = pick_slot(1'b0, 1'b0);
        if (s >= 0) queue_cmd(FUNC_LINK, slot_t'(s), pick_size(), hold);
        else queue_cmd(FUNC_GET, slot_t'($urandom), pick_size(), hold);
      end else begin
        s = pick_slot(1'b1, 1'b0);
        if (s >= 0) queue_cmd(FUNC_UNLINK, slot_t'(s), size_t'($urandom), hold);
        else queue_cmd(FUNC_LINK, slot_t'(pick_slot(1'b0, 1'b0)), pick_size(), hold);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || start || pending_grants.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && pending_grants.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/hffl_pkg.sv
design/head_fit_free_list_top.sv
tb/tb_head_fit_free_list_top.sv
